FILE: hdl/ssld_pkg.sv
// Shared types and constants for the sync/start/length deframer.
// No dependencies; imported by every module in hdl/.
package ssld_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_SYNC_VALUE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_VALUE = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] START_RESET = 8'h55;
    localparam logic [LEN_W-1:0]  MAXLEN_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_START   = 3'd1,
        PH_ID      = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5
    } ssld_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] start_value;
        logic [LEN_W-1:0]  max_length;
    } ssld_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_id;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_offset;
        logic [LEN_W-1:0]  packet_length;
        logic              last_byte;
    } ssld_result_t;

endpackage

FILE: hdl/sync_start_length_deframer_core.sv
// Top level of the sync/start/length packet deframer.
// Depends on ssld_pkg, ssld_cfg_regs, ssld_frame_fsm, ssld_out_reg.
//
// One received byte per beat on rx_byte; one beat is accepted every clock
// cycle while the output is drained. Each byte passes the input register and
// is parsed from it while the result register is open; a payload byte is then
// written to the result register, which drives out_valid. While a held result
// is stalled, the input register cannot advance and in_stall follows out_stall
// in the same cycle. Frames are sync, start, id, length low, length high, then
// payload. Headers with a zero length or a length above max_length are dropped
// without output. Configuration writes are taken every cycle (cfg_ready is
// always high) and should be made only while no frame is in progress.
module sync_start_length_deframer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ssld_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ssld_pkg::BYTE_W-1:0] packet_id,
    output logic [ssld_pkg::BYTE_W-1:0] payload_byte,
    output logic [ssld_pkg::LEN_W-1:0]  byte_offset,
    output logic [ssld_pkg::LEN_W-1:0]  packet_length,
    output logic                        last_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ssld_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ssld_pkg::LEN_W-1:0]  cfg_data
);
    import ssld_pkg::*;

    ssld_cfg_t    cfg;
    ssld_result_t res;
    logic         res_valid;
    logic         res_open;

    ssld_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssld_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_open  (res_open),
        .res_valid (res_valid),
        .res       (res)
    );

    ssld_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .res_open      (res_open),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_id     (packet_id),
        .payload_byte  (payload_byte),
        .byte_offset   (byte_offset),
        .packet_length (packet_length),
        .last_byte     (last_byte)
    );

endmodule

FILE: hdl/ssld_cfg_regs.sv
// Configuration register file: sync value, start value, maximum length.
// Depends on ssld_pkg.
module ssld_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ssld_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ssld_pkg::LEN_W-1:0]  cfg_data,
    output ssld_pkg::ssld_cfg_t         cfg
);
    import ssld_pkg::*;

    ssld_cfg_t cfg_reg;
    ssld_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SYNC_VALUE:  cfg_next.sync_value  = cfg_data[BYTE_W-1:0];
                REG_START_VALUE: cfg_next.start_value = cfg_data[BYTE_W-1:0];
                REG_MAX_LENGTH:  cfg_next.max_length  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value  <= SYNC_RESET;
            cfg_reg.start_value <= START_RESET;
            cfg_reg.max_length  <= MAXLEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/ssld_frame_fsm.sv
// Input beat register and frame parser state machine.
// Depends on ssld_pkg; feeds ssld_out_reg.
module ssld_frame_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ssld_pkg::BYTE_W-1:0] rx_byte,
    input  ssld_pkg::ssld_cfg_t         cfg,
    input  logic                        res_open,
    output logic                        res_valid,
    output ssld_pkg::ssld_result_t      res
);
    import ssld_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    ssld_phase_t       phase_reg, phase_next;
    logic [BYTE_W-1:0] held_id_reg, held_id_next;
    logic [LEN_W-1:0]  held_length_reg, held_length_next;
    logic [LEN_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic [LEN_W-1:0]  seen_inc;
    logic [LEN_W-1:0]  hdr_length;
    logic              last;
    logic              s1_go;
    logic              take_in;

    assign s1_go    = s1_valid_reg && res_open;
    assign in_stall = s1_valid_reg && !res_open;
    assign take_in  = in_valid && !in_stall;

    assign seen_inc   = bytes_seen_reg + 16'd1;
    assign hdr_length = {s1_byte_reg, held_length_reg[BYTE_W-1:0]};
    assign last       = (seen_inc == held_length_reg) || (held_length_reg == '0);

    always_comb
    begin
        s1_valid_next    = take_in ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        phase_next       = phase_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        bytes_seen_next  = bytes_seen_reg;
        res_valid        = 1'b0;
        res.packet_id     = held_id_reg;
        res.payload_byte  = s1_byte_reg;
        res.byte_offset   = bytes_seen_reg;
        res.packet_length = held_length_reg;
        res.last_byte     = last;
        if (s1_go)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (s1_byte_reg == cfg.sync_value)
                        phase_next = PH_START;
                end
                PH_START:
                begin
                    phase_next = (s1_byte_reg == cfg.start_value) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    held_id_next = s1_byte_reg;
                    phase_next   = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    held_length_next = {{(LEN_W-BYTE_W){1'b0}}, s1_byte_reg};
                    phase_next       = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    held_length_next = hdr_length;
                    if (hdr_length != '0 && hdr_length <= cfg.max_length)
                    begin
                        bytes_seen_next = '0;
                        phase_next      = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid       = 1'b1;
                    bytes_seen_next = seen_inc;
                    if (last)
                        phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_HUNT;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            bytes_seen_reg  <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            phase_reg       <= phase_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            bytes_seen_reg  <= bytes_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            s1_byte_reg <= rx_byte;
    end

    a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> held_length_reg != '0)
        else $error("payload phase with zero held length");

    a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_seen_reg < held_length_reg)
        else $error("payload count reached held length");

    a_last_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_byte |=> phase_reg == PH_HUNT)
        else $error("last payload beat did not return to hunt");

    a_result_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> s1_go && phase_reg == PH_PAYLOAD)
        else $error("result outside payload phase");

endmodule

FILE: hdl/ssld_out_reg.sv
// Result register between the parser and the output channel.
// Depends on ssld_pkg; driven by ssld_frame_fsm.
module ssld_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    input  ssld_pkg::ssld_result_t      res,
    output logic                        res_open,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ssld_pkg::BYTE_W-1:0] packet_id,
    output logic [ssld_pkg::BYTE_W-1:0] payload_byte,
    output logic [ssld_pkg::LEN_W-1:0]  byte_offset,
    output logic [ssld_pkg::LEN_W-1:0]  packet_length,
    output logic                        last_byte
);
    import ssld_pkg::*;

    logic         out_valid_reg, out_valid_next;
    ssld_result_t out_data_reg;

    assign res_open       = !out_valid_reg || !out_stall;
    assign out_valid_next = res_open ? res_valid : out_valid_reg;

    assign out_valid     = out_valid_reg;
    assign packet_id     = out_data_reg.packet_id;
    assign payload_byte  = out_data_reg.payload_byte;
    assign byte_offset   = out_data_reg.byte_offset;
    assign packet_length = out_data_reg.packet_length;
    assign last_byte     = out_data_reg.last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_open && res_valid)
            out_data_reg <= res;
    end

    a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.byte_offset < out_data_reg.packet_length)
        else $error("offset not below packet length");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.last_byte |->
            ({1'b0, out_data_reg.byte_offset} + 17'd1)
                == {1'b0, out_data_reg.packet_length})
        else $error("last flag not on final offset");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !res_open)
        else $error("held result could be overwritten");

endmodule

FILE: dv/testbench.sv
// Testbench for sync_start_length_deframer_core: drives framed byte streams with
// random idling and back-pressure, predicts every payload beat and checks them.
// Depends on ssld_pkg and the core RTL in hdl/.
module testbench;
    import ssld_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] packet_id;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  packet_length;
    logic              last_byte;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [LEN_W-1:0]  cfg_data;

    ssld_cfg_t         cfg_shadow = '{SYNC_RESET, START_RESET, MAXLEN_RESET};
    ssld_phase_t       ph = PH_HUNT;
    logic [BYTE_W-1:0] held_id = '0;
    logic [LEN_W-1:0]  held_len = '0;
    logic [LEN_W-1:0]  byte_count = '0;
    ssld_result_t      pending_payload[$];
    ssld_result_t      seen_beat;
    ssld_result_t      want_beat;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int fail_count = 0;
    int stuck_cycles = 0;

    sync_start_length_deframer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_id     (packet_id),
        .payload_byte  (payload_byte),
        .byte_offset   (byte_offset),
        .packet_length (packet_length),
        .last_byte     (last_byte),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        ssld_result_t beat;
        case (ph)
            PH_HUNT:
            begin
                if (b == cfg_shadow.sync_value)
                    ph = PH_START;
            end
            PH_START:
                ph = (b == cfg_shadow.start_value) ? PH_ID : PH_HUNT;
            PH_ID:
            begin
                held_id = b;
                ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                held_len = {8'h00, b};
                ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                held_len[LEN_W-1:BYTE_W] = b;
                if (held_len != 0 && held_len <= cfg_shadow.max_length)
                begin
                    byte_count = '0;
                    ph = PH_PAYLOAD;
                end
                else
                    ph = PH_HUNT;
            end
            PH_PAYLOAD:
            begin
                beat.packet_id     = held_id;
                beat.payload_byte  = b;
                beat.byte_offset   = byte_count;
                beat.packet_length = held_len;
                byte_count = byte_count + 1'b1;
                beat.last_byte = (byte_count == held_len) || (held_len == 0);
                pending_payload.push_back(beat);
                if (beat.last_byte)
                    ph = PH_HUNT;
            end
            default:
                ph = PH_HUNT;
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= BYTE_W'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_payload.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SYNC_VALUE:  cfg_shadow.sync_value  = data[BYTE_W-1:0];
            REG_START_VALUE: cfg_shadow.start_value = data[BYTE_W-1:0];
            REG_MAX_LENGTH:  cfg_shadow.max_length  = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drive the parser back to hunting with filler bytes, running out any payload that opens
    task automatic resync();
        while (ph != PH_HUNT)
        begin
            case (ph)
                PH_START:   send_byte(cfg_shadow.start_value ^ 8'h01);
                PH_PAYLOAD: send_byte(BYTE_W'($urandom));
                default:    send_byte(8'h00);
            endcase
        end
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len);
        resync();
        send_byte(cfg_shadow.sync_value);
        send_byte(cfg_shadow.start_value);
        send_byte(id);
        send_byte(len[BYTE_W-1:0]);
        send_byte(len[LEN_W-1:BYTE_W]);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len);
        send_header(id, len);
        while (ph == PH_PAYLOAD)
            send_byte(BYTE_W'($urandom));
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int          r;
        int unsigned top;
        r   = $urandom_range(99);
        top = cfg_shadow.max_length;
        if (r < 65)
            return LEN_W'($urandom_range(1, 8));
        if (r < 80)
            return LEN_W'($urandom_range(9, 40));
        if (r < 88)
            return '0;
        if (r < 94 && top < 16'hFFFF)
            return LEN_W'($urandom_range(top + 1, 16'hFFFF));
        return LEN_W'($urandom_range(256, 300));
    endfunction

    task automatic test_basic_framing();
        send_header(8'hFF, 16'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        // wrong start byte, here equal to the sync value
        send_byte(cfg_shadow.sync_value);
        send_byte(cfg_shadow.sync_value);
        send_byte(cfg_shadow.start_value);
        send_header(8'h00, 16'd0);
    endtask

    task automatic test_register_writes();
        wait_idle();
        write_reg(REG_SYNC_VALUE, 16'hFF00);
        write_reg(REG_START_VALUE, 16'h00FF);
        write_reg(REG_MAX_LENGTH, 16'd1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_header(8'h7E, 16'd2);
        send_header(8'h81, 16'd1);
        send_byte(8'hAA);
        wait_idle();
        write_reg(REG_MAX_LENGTH, 16'd0);
        send_header(8'h3C, 16'd1);
        wait_idle();
        write_reg(REG_MAX_LENGTH, 16'hFFFF);
        write_reg(REG_SYNC_VALUE, 16'h00AA);
        write_reg(REG_START_VALUE, 16'h0055);
    endtask

    task automatic test_mid_frame_writes();
        send_byte(cfg_shadow.sync_value);
        send_byte(cfg_shadow.start_value);
        send_byte(8'h42);
        send_byte(8'h04);
        wait_idle();
        write_reg(REG_MAX_LENGTH, 16'd3);
        send_byte(8'h00);
        send_header(8'h43, 16'd3);
        send_byte(8'h11);
        wait_idle();
        // payload in flight keeps its held length
        write_reg(REG_MAX_LENGTH, 16'd1);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        write_reg(REG_MAX_LENGTH, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int n_bytes);
        int                stop_at;
        int                r;
        logic [BYTE_W-1:0] wrong;
        wait_idle();
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        write_reg(REG_SYNC_VALUE, LEN_W'($urandom));
        write_reg(REG_START_VALUE, LEN_W'($urandom));
        write_reg(REG_MAX_LENGTH, $urandom_range(1) ? 16'hFFFF : LEN_W'($urandom_range(1, 300)));
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 80)
                send_frame(BYTE_W'($urandom), pick_length());
            else if (r < 88)
            begin
                resync();
                send_byte(cfg_shadow.sync_value);
                wrong = $urandom_range(1) ? cfg_shadow.sync_value : BYTE_W'($urandom);
                if (wrong == cfg_shadow.start_value)
                    wrong = wrong ^ 8'h01;
                send_byte(wrong);
            end
            else
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_LENGTH, 16'hFFFF);
        hold_req = 300;
        send_frame(8'h5A, 16'd100);
        wait_idle();
    endtask

    // full-range length: dropped just above max_length, then opened; only the
    // first payload beats are sent
    task automatic test_longest_packet();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MAX_LENGTH, 16'hFFFE);
        send_header(8'hA5, 16'hFFFF);
        wait_idle();
        write_reg(REG_MAX_LENGTH, 16'hFFFF);
        send_header(8'hA5, 16'hFFFF);
        repeat (16) send_byte(BYTE_W'($urandom));
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_beat.packet_id     = packet_id;
            seen_beat.payload_byte  = payload_byte;
            seen_beat.byte_offset   = byte_offset;
            seen_beat.packet_length = packet_length;
            seen_beat.last_byte     = last_byte;
            if (pending_payload.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected payload beat: id %h byte %h offset %0d length %0d last %b",
                             packet_id, payload_byte, byte_offset, packet_length, last_byte);
                fail_count++;
            end
            else
            begin
                want_beat = pending_payload.pop_front();
                if (seen_beat !== want_beat)
                begin
                    if (fail_count < 10)
                        $display({"payload beat mismatch: expected id %h byte %h offset %0d ",
                                  "length %0d last %b, got id %h byte %h offset %0d ",
                                  "length %0d last %b"},
                                 want_beat.packet_id, want_beat.payload_byte,
                                 want_beat.byte_offset, want_beat.packet_length,
                                 want_beat.last_byte, packet_id, payload_byte,
                                 byte_offset, packet_length, last_byte);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("sync_start_length_deframer_core test failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_framing();
        test_register_writes();
        test_mid_frame_writes();
        test_random_traffic(24, 73, 90);
        test_random_traffic(73, 24, 90);
        test_random_traffic(0, 0, 90);
        test_backpressure();
        test_longest_packet();
        wait_idle();
        if (fail_count == 0)
            $display("sync_start_length_deframer_core test passed");
        else
            $display("sync_start_length_deframer_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/ssld_pkg.sv
hdl/ssld_cfg_regs.sv
hdl/ssld_frame_fsm.sv
hdl/ssld_out_reg.sv
hdl/sync_start_length_deframer_core.sv
dv/testbench.sv
